### sv/assert_macros.svh
// Assertion macros used by the checker file of the valve timer.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property that holds at every edge.
`define WATVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition at one edge is followed by another at the next edge.
`define WATVT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/watvt_pkg.sv
// Package for the weekly alarm table valve timer: entry field layout,
// microcode word type and the microcode program. No dependencies.
package watvt_pkg;

  localparam int unsigned ENTRY_W   = 27;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned VALVE_MAX = 2;
  localparam int unsigned TS_W      = 32;
  localparam int unsigned DUR_W     = 7;
  localparam int unsigned THR_W     = 23;
  localparam logic [THR_W-1:0] MS_PER_MINUTE = THR_W'(60000);

  // Entry register layout.
  localparam int unsigned ENT_ACTIVE = 26;
  localparam int unsigned ENT_VALVE  = 25;
  localparam int unsigned ENT_DAY_HI = 24;
  localparam int unsigned ENT_DAY_LO = 18;
  localparam int unsigned ENT_HR_HI  = 17;
  localparam int unsigned ENT_HR_LO  = 13;
  localparam int unsigned ENT_MN_HI  = 12;
  localparam int unsigned ENT_MN_LO  = 7;
  localparam int unsigned ENT_DUR_HI = 6;

  typedef logic [2:0] upc_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_WAIT_IN,
    JC_LOOP_ENT,
    JC_LOOP_VALVE,
    JC_WAIT_OUT
  } jump_cond_e;

  typedef struct packed {
    logic       ld_in;
    logic       match;
    logic       calc;
    logic       cmp;
    logic       emit;
    jump_cond_e cond;
    upc_t       target;
  } uword_t;

  // Program step addresses.
  localparam upc_t ST_FETCH = 3'd0;
  localparam upc_t ST_MATCH = 3'd1;
  localparam upc_t ST_CALC  = 3'd2;
  localparam upc_t ST_CMP   = 3'd3;
  localparam upc_t ST_EMIT  = 3'd4;

  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    w = '{ld_in: 1'b0, match: 1'b0, calc: 1'b0, cmp: 1'b0, emit: 1'b0,
           cond: JC_NEXT, target: ST_FETCH};
    unique case (pc)
      ST_FETCH: begin
        w.ld_in = 1'b1;
        w.cond  = JC_WAIT_IN;
      end
      ST_MATCH: begin
        w.match  = 1'b1;
        w.cond   = JC_LOOP_ENT;
        w.target = ST_MATCH;
      end
      ST_CALC: begin
        w.calc = 1'b1;
      end
      ST_CMP: begin
        w.cmp    = 1'b1;
        w.cond   = JC_LOOP_VALVE;
        w.target = ST_CALC;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = JC_WAIT_OUT;
        w.target = ST_FETCH;
      end
      default: begin
        w.target = ST_FETCH;
        w.cond   = JC_WAIT_OUT;
      end
    endcase
    return w;
  endfunction

endpackage

### sv/weekly_alarm_table_valve_timer.sv
// Channel  | Direction | Handshake              | Payload
// request  | in        | in_valid_i/in_stall_o   | weekday, hour_now, minute_now, now_ms,
//          |           |                        | valve_open_now
// result   | out       | out_valid_o/out_stall_i | open_cmd, close_cmd
// config   | in        | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// A request walks the microcode: a fetch step, then one alarm entry per cycle
// through a single matcher, then a timestamp step and a compare step per valve,
// then an emit step.
// Reset clears the entries, the valve timers and the sequencer at once.
// A new request is taken while the previous result still waits on out_stall_i;
// the last step holds until the output register is free.
// Depends on watvt_pkg.
module weekly_alarm_table_valve_timer
  import watvt_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT = 6,
  parameter int unsigned VALVE_COUNT = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ENTRY_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           weekday_i,
  input  logic [4:0]           hour_now_i,
  input  logic [5:0]           minute_now_i,
  input  logic [31:0]          now_ms_i,
  input  logic [1:0]           valve_open_now_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           open_cmd_o,
  output logic [1:0]           close_cmd_o
);

  localparam int unsigned EIW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam logic [EIW-1:0] ENT_LAST = EIW'(ENTRY_COUNT - 1);
  localparam logic VALVE_LAST = 1'(VALVE_COUNT - 1);

  logic [ENTRY_W-1:0] entry_q [ENTRY_COUNT];
  logic [TS_W-1:0]    opened_at_q [VALVE_MAX];
  logic [DUR_W-1:0]   held_q [VALVE_MAX];

  upc_t pc_q, pc_d;
  uword_t uw;

  logic [EIW-1:0] eidx_q;
  logic           vidx_q;

  logic [2:0]      wd_q;
  logic [4:0]      hr_q;
  logic [5:0]      mn_q;
  logic [TS_W-1:0] now_q;
  logic [1:0]      open_now_q;
  logic [1:0]      open_acc_q;
  logic [1:0]      close_acc_q;

  logic [TS_W-1:0]  diff_q;
  logic [THR_W-1:0] thr_q;

  logic       out_valid_q;
  logic [1:0] open_out_q;
  logic [1:0] close_out_q;

  logic               in_acc;
  logic               out_free;
  logic [ENTRY_W-1:0] ent;
  logic               ent_hit;
  logic [1:0]         open_all;
  logic               close_hit;

  assign uw       = ucode_rom(pc_q);
  assign in_acc   = uw.ld_in && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // Entry match: weekday seven has no mask bit, so it never matches.
  assign ent = entry_q[eidx_q];
  assign ent_hit = ent[ENT_ACTIVE]
                && ({1'b0, ent[ENT_VALVE]} < 2'(VALVE_COUNT))
                && (wd_q != 3'd7)
                && ent[ENT_DAY_LO + 32'(wd_q)]
                && (ent[ENT_HR_HI:ENT_HR_LO] == hr_q)
                && (ent[ENT_MN_HI:ENT_MN_LO] == mn_q);

  // A valve opened in this request counts as open for the close test.
  assign open_all  = open_now_q | open_acc_q;
  assign close_hit = (opened_at_q[vidx_q] != '0) && open_all[vidx_q]
                  && (diff_q >= {{(TS_W-THR_W){1'b0}}, thr_q});

  always_comb begin
    pc_d = pc_q;
    unique case (uw.cond)
      JC_NEXT:       pc_d = pc_q + 3'd1;
      JC_WAIT_IN:    if (in_acc) pc_d = pc_q + 3'd1;
      JC_LOOP_ENT:   pc_d = (eidx_q != ENT_LAST) ? uw.target : pc_q + 3'd1;
      JC_LOOP_VALVE: pc_d = (vidx_q != VALVE_LAST) ? uw.target : pc_q + 3'd1;
      JC_WAIT_OUT:   if (out_free) pc_d = uw.target;
      default:       pc_d = ST_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ST_FETCH;
      eidx_q      <= '0;
      vidx_q      <= 1'b0;
      open_acc_q  <= '0;
      close_acc_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ENTRY_COUNT; i++) entry_q[i] <= '0;
      for (int v = 0; v < VALVE_MAX; v++) begin
        opened_at_q[v] <= '0;
        held_q[v]      <= '0;
      end
    end else begin
      pc_q <= pc_d;

      if (cfg_we_i && ({1'b0, cfg_index_i} < 4'(ENTRY_COUNT))) begin
        entry_q[cfg_index_i[EIW-1:0]] <= cfg_wdata_i;
      end

      if (in_acc) begin
        wd_q        <= weekday_i;
        hr_q        <= hour_now_i;
        mn_q        <= minute_now_i;
        now_q       <= now_ms_i;
        open_now_q  <= valve_open_now_i;
        open_acc_q  <= '0;
        close_acc_q <= '0;
        eidx_q      <= '0;
        vidx_q      <= 1'b0;
      end

      if (uw.match) begin
        if (ent_hit) begin
          open_acc_q[ent[ENT_VALVE]]  <= 1'b1;
          opened_at_q[ent[ENT_VALVE]] <= now_q;
          held_q[ent[ENT_VALVE]]      <= ent[ENT_DUR_HI:0];
        end
        if (eidx_q != ENT_LAST) eidx_q <= eidx_q + EIW'(1);
      end

      // Comparing the raw difference with duration * 60000 gives the same
      // answer as comparing whole elapsed minutes with the duration.
      if (uw.calc) begin
        diff_q <= now_q - opened_at_q[vidx_q];
        thr_q  <= THR_W'(held_q[vidx_q]) * MS_PER_MINUTE;
      end

      if (uw.cmp) begin
        if (close_hit) begin
          close_acc_q[vidx_q] <= 1'b1;
          opened_at_q[vidx_q] <= '0;
        end
        if (vidx_q != VALVE_LAST) vidx_q <= 1'b1;
      end

      if (uw.emit && out_free) begin
        out_valid_q <= 1'b1;
        open_out_q  <= open_acc_q;
        close_out_q <= close_acc_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = !uw.ld_in;
  assign out_valid_o = out_valid_q;
  assign open_cmd_o  = open_out_q;
  assign close_cmd_o = close_out_q;

endmodule

### sv/watvt_checker.sv
// Port-level checker for the weekly alarm table valve timer, bound to the top.
// Depends on assert_macros.svh and the top level's port list.
`include "assert_macros.svh"

module watvt_checker #(
  parameter int unsigned VALVE_COUNT = 2
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] open_cmd_o,
  input logic [1:0] close_cmd_o
);

  // A result that waits keeps its valid.
  `WATVT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // Work on one request at a time: the input stalls right after a request.
  `WATVT_ASSERT_NEXT(a_one_at_a_time, in_valid_i && !in_stall_o, in_stall_o, "request taken while busy")

  // No result can appear in the cycle after a request is taken.
  `WATVT_ASSERT_NEXT(a_no_instant, in_valid_i && !in_stall_o && !out_valid_o, !out_valid_o, "result too early")

  // A valve that does not exist is never commanded.
  `WATVT_ASSERT(a_valve_range, !(out_valid_o && (VALVE_COUNT < 2)) || (!open_cmd_o[1] && !close_cmd_o[1]), "missing valve commanded")

endmodule

bind weekly_alarm_table_valve_timer watvt_checker #(
  .VALVE_COUNT(VALVE_COUNT)
) u_watvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .open_cmd_o  (open_cmd_o),
  .close_cmd_o (close_cmd_o)
);

### tb/weekly_alarm_table_valve_timer_test.sv
// Self-checking testbench for weekly_alarm_table_valve_timer: a scoreboard class predicts
// the open and close commands of each clock check, and plain tasks drive the block.
// Depends on watvt_pkg and the weekly_alarm_table_valve_timer RTL.
`timescale 1ns / 1ps

import watvt_pkg::*;

localparam int unsigned ALARM_SLOTS   = 6;
localparam int unsigned CFG_SLOTS     = 1 << CFG_IDX_W;
localparam int unsigned DAYS_PER_WEEK = 7;

typedef struct packed {
  logic [1:0] opens;
  logic [1:0] closes;
} valve_cmd_t;

class valve_timer_scoreboard;
  logic [ENTRY_W-1:0] alarm_entry [ALARM_SLOTS];
  logic [TS_W-1:0]    opened_at [VALVE_MAX];
  logic [DUR_W-1:0]   hold_minutes [VALVE_MAX];
  valve_cmd_t         awaited [$];
  int unsigned        failures;
  int unsigned        results_seen;
  int unsigned        opens_seen;
  int unsigned        closes_seen;

  function new();
    foreach (alarm_entry[i]) alarm_entry[i] = '0;
    foreach (opened_at[v]) begin
      opened_at[v]    = '0;
      hold_minutes[v] = '0;
    end
    failures     = 0;
    results_seen = 0;
    opens_seen   = 0;
    closes_seen  = 0;
  endfunction

  // Writes to the spare register indexes are dropped by the block.
  function void set_entry(int unsigned idx, logic [ENTRY_W-1:0] value);
    if (idx < ALARM_SLOTS) alarm_entry[idx] = value;
  endfunction

  function valve_cmd_t note_check(logic [2:0] wd, logic [4:0] hr, logic [5:0] mn,
                                  logic [TS_W-1:0] now_ms, logic [1:0] open_now);
    valve_cmd_t       want;
    logic [ENTRY_W-1:0] e;
    logic [TS_W-1:0]  span;
    logic [TS_W-1:0]  whole_minutes;
    logic             hit;
    logic             vsel;
    want = '0;
    for (int i = 0; i < ALARM_SLOTS; i++) begin
      e    = alarm_entry[i];
      vsel = e[ENT_VALVE];
      hit  = e[ENT_ACTIVE] && (wd < DAYS_PER_WEEK) && e[ENT_DAY_LO + wd]
             && (e[ENT_HR_HI:ENT_HR_LO] == hr) && (e[ENT_MN_HI:ENT_MN_LO] == mn);
      if (hit) begin
        want.opens[vsel]   = 1'b1;
        opened_at[vsel]    = now_ms;
        hold_minutes[vsel] = e[ENT_DUR_HI:0];
      end
    end
    // A valve opened in this check already counts as open for the close test.
    for (int v = 0; v < VALVE_MAX; v++) begin
      if (opened_at[v] != '0 && (open_now[v] || want.opens[v])) begin
        span          = now_ms - opened_at[v];
        whole_minutes = span / TS_W'(MS_PER_MINUTE);
        if (whole_minutes >= TS_W'(hold_minutes[v])) begin
          want.closes[v] = 1'b1;
          opened_at[v]   = '0;
        end
      end
    end
    awaited.push_back(want);
    return want;
  endfunction

  function void check_command(logic [1:0] opens, logic [1:0] closes);
    valve_cmd_t want;
    if (awaited.size() == 0) begin
      failures++;
      $display("%0t: result with nothing awaited, open_cmd %b close_cmd %b",
               $time, opens, closes);
      return;
    end
    want = awaited.pop_front();
    results_seen++;
    if (opens != 2'b00) opens_seen++;
    if (closes != 2'b00) closes_seen++;
    if (opens !== want.opens) begin
      failures++;
      $display("%0t: open_cmd expected %b, got %b", $time, want.opens, opens);
    end
    if (closes !== want.closes) begin
      failures++;
      $display("%0t: close_cmd expected %b, got %b", $time, want.closes, closes);
    end
  endfunction
endclass

module weekly_alarm_table_valve_timer_test;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_CHECKS = 255;
  localparam int unsigned LAST_CHECKS  = 115;
  localparam int unsigned CALM_PHASE   = 3;
  localparam logic        VALVE_1      = 1'b0;
  localparam logic        VALVE_2      = 1'b1;
  localparam logic [6:0]  ALL_DAYS     = 7'h7F;
  localparam logic [6:0]  MONDAY       = 7'h01;
  localparam logic [6:0]  TUESDAY      = 7'h02;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ENTRY_W-1:0]   cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           weekday;
  logic [4:0]           hour_now;
  logic [5:0]           minute_now;
  logic [31:0]          now_ms;
  logic [1:0]           valve_open_now;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           open_cmd;
  logic [1:0]           close_cmd;

  valve_timer_scoreboard sb;
  logic [ENTRY_W-1:0]    alarm_plan [ALARM_SLOTS];
  logic [1:0]            valve_phys;
  logic [31:0]           ms_clock;
  bit                    calm;
  int unsigned           cycles;
  int unsigned           checks_sent;
  int unsigned           settings_loaded;

  weekly_alarm_table_valve_timer dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .weekday_i        (weekday),
    .hour_now_i       (hour_now),
    .minute_now_i     (minute_now),
    .now_ms_i         (now_ms),
    .valve_open_now_i (valve_open_now),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .open_cmd_o       (open_cmd),
    .close_cmd_o      (close_cmd)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d results outstanding", sb.awaited.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: values read here are the ones present just before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_command(open_cmd, close_cmd);
    out_stall <= !calm && ($urandom_range(99) < 29);
  end

  function automatic logic [ENTRY_W-1:0] pack_entry(logic active, logic valve, logic [6:0] days,
                                                    logic [4:0] hr, logic [5:0] mn,
                                                    logic [6:0] dur);
    logic [ENTRY_W-1:0] e;
    e = '0;
    e[ENT_ACTIVE]            = active;
    e[ENT_VALVE]             = valve;
    e[ENT_DAY_HI:ENT_DAY_LO] = days;
    e[ENT_HR_HI:ENT_HR_LO]   = hr;
    e[ENT_MN_HI:ENT_MN_LO]   = mn;
    e[ENT_DUR_HI:0]          = dur;
    return e;
  endfunction

  // Writes every register index, the spare ones with random data.
  task automatic load_table();
    logic [ENTRY_W-1:0] wdata;
    for (int i = 0; i < CFG_SLOTS; i++) begin
      wdata = (i < ALARM_SLOTS) ? alarm_plan[i] : ENTRY_W'($urandom);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= wdata;
      @(posedge clk);
      sb.set_entry(i, wdata);
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic drain();
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_check(input logic [2:0] wd, input logic [4:0] hr, input logic [5:0] mn,
                            input logic [31:0] ms, input logic [1:0] open_now);
    valve_cmd_t want;
    if (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    weekday        <= wd;
    hour_now       <= hr;
    minute_now     <= mn;
    now_ms         <= ms;
    valve_open_now <= open_now;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want       = sb.note_check(wd, hr, mn, ms, open_now);
    valve_phys = (valve_phys | want.opens) & ~want.closes;
    checks_sent++;
  endtask

  task automatic fill_random_plan();
    logic [6:0] days;
    logic [4:0] hr;
    logic [5:0] mn;
    logic [6:0] dur;
    for (int i = 0; i < ALARM_SLOTS; i++) begin
      days = ($urandom_range(99) < 25) ? ALL_DAYS : 7'($urandom);
      hr   = ($urandom_range(99) < 90) ? 5'($urandom_range(23)) : 5'($urandom_range(31, 24));
      mn   = ($urandom_range(99) < 90) ? 6'($urandom_range(59)) : 6'($urandom_range(63, 60));
      if ($urandom_range(99) < 70) dur = 7'($urandom_range(4));
      else if ($urandom_range(99) < 65) dur = 7'($urandom_range(20, 5));
      else dur = 7'($urandom_range(127));
      alarm_plan[i] = pack_entry($urandom_range(99) < 85, 1'($urandom), days, hr, mn, dur);
      // Shared alarm times make several entries hit in one check.
      if (i > 0 && $urandom_range(99) < 30) begin
        alarm_plan[i][ENT_HR_HI:ENT_MN_LO] = alarm_plan[0][ENT_HR_HI:ENT_MN_LO];
        alarm_plan[i][ENT_DAY_HI:ENT_DAY_LO] = ALL_DAYS;
      end
    end
  endtask

  // Mostly checks that hit a planned alarm, on a millisecond clock that mostly moves forward in random steps.
  task automatic send_random_check();
    logic [ENTRY_W-1:0] e;
    logic [6:0]         days;
    logic [2:0]         wd;
    logic [4:0]         hr;
    logic [5:0]         mn;
    logic [1:0]         open_now;
    int unsigned        pick;
    if ($urandom_range(99) < 55) begin
      e    = alarm_plan[$urandom_range(ALARM_SLOTS - 1)];
      days = e[ENT_DAY_HI:ENT_DAY_LO];
      if (days == '0) begin
        wd = 3'($urandom_range(7));
      end else begin
        wd = 3'($urandom_range(DAYS_PER_WEEK - 1));
        while (!days[wd]) wd = 3'($urandom_range(DAYS_PER_WEEK - 1));
      end
      hr = e[ENT_HR_HI:ENT_HR_LO];
      mn = e[ENT_MN_HI:ENT_MN_LO];
    end else begin
      wd = 3'($urandom_range(7));
      hr = ($urandom_range(99) < 80) ? 5'($urandom_range(23)) : 5'($urandom_range(31));
      mn = ($urandom_range(99) < 80) ? 6'($urandom_range(59)) : 6'($urandom_range(63));
    end
    pick = $urandom_range(99);
    if (pick < 3) ms_clock = '0;
    else if (pick < 6) ms_clock = $urandom;
    else if (pick < 9) ms_clock = 32'hFFFF_FFFF - $urandom_range(200000);
    else ms_clock = ms_clock + $urandom_range(90000);
    open_now = ($urandom_range(99) < 80) ? valve_phys : 2'($urandom_range(3));
    send_check(wd, hr, mn, ms_clock, open_now);
  endtask

  initial begin
    int unsigned count;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    weekday        = '0;
    hour_now       = '0;
    minute_now     = '0;
    now_ms         = '0;
    valve_open_now = '0;
    out_stall      = 1'b0;
    valve_phys     = '0;
    ms_clock       = 32'd1000;
    calm           = 1'b0;
    cycles         = 0;
    checks_sent    = 0;
    settings_loaded = 0;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The table is empty out of reset, so nothing may match.
    send_check(3'd0, 5'd8, 6'd30, 32'd1000, 2'b00);
    send_check(3'd7, 5'd31, 6'd63, 32'hFFFF_FFFF, 2'b11);
    in_valid <= 1'b0;
    drain();

    alarm_plan[0] = pack_entry(1'b1, VALVE_1, MONDAY, 5'd8, 6'd30, 7'd0);
    alarm_plan[1] = pack_entry(1'b1, VALVE_2, ALL_DAYS, 5'd8, 6'd30, 7'd2);
    alarm_plan[2] = pack_entry(1'b1, VALVE_2, TUESDAY, 5'd8, 6'd30, 7'd5);
    alarm_plan[3] = pack_entry(1'b0, VALVE_1, ALL_DAYS, 5'd8, 6'd30, 7'd1);
    alarm_plan[4] = pack_entry(1'b1, VALVE_1, ALL_DAYS, 5'd31, 6'd63, 7'd1);
    alarm_plan[5] = '1;
    load_table();
    // Zero duration opens and closes in one check; the other valve runs two minutes.
    send_check(3'd0, 5'd8, 6'd30, 32'd1000, 2'b00);
    send_check(3'd0, 5'd8, 6'd31, 32'd61000, 2'b10);
    // Timed but reported closed: no command, the timer stays.
    send_check(3'd0, 5'd8, 6'd32, 32'd121000, 2'b00);
    send_check(3'd0, 5'd8, 6'd33, 32'd121001, 2'b10);
    // Two entries on one valve: the later one's duration wins.
    send_check(3'd1, 5'd8, 6'd30, 32'd200000, 2'b00);
    send_check(3'd1, 5'd8, 6'd35, 32'd499999, 2'b10);
    send_check(3'd1, 5'd8, 6'd36, 32'd500000, 2'b10);
    // Out-of-range hour and minute match as raw bits.
    send_check(3'd6, 5'd31, 6'd63, 32'd5000, 2'b00);
    send_check(3'd2, 5'd0, 6'd0, 32'd65000, 2'b11);
    // Weekday seven matches nothing; the timestamp going back wraps to a huge span.
    send_check(3'd7, 5'd8, 6'd30, 32'd10, 2'b11);
    // A match at timestamp zero leaves the valve untimed.
    send_check(3'd1, 5'd8, 6'd30, 32'd0, 2'b00);
    send_check(3'd1, 5'd8, 6'd31, 32'd999999, 2'b10);
    // Timer started just before the timestamp wraps.
    send_check(3'd0, 5'd8, 6'd30, 32'hFFFF_FFF0, 2'b01);
    send_check(3'd3, 5'd9, 6'd0, 32'd119984, 2'b10);
    send_check(3'd5, 5'd24, 6'd60, 32'd130000, 2'b11);
    in_valid <= 1'b0;
    valve_phys = '0;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 0) begin
        foreach (alarm_plan[i]) alarm_plan[i] = '1;
      end else if (p == PHASES - 1) begin
        foreach (alarm_plan[i]) alarm_plan[i] = '0;
      end else begin
        fill_random_plan();
      end
      load_table();
      calm  = (p == CALM_PHASE);
      count = (p == PHASES - 1) ? LAST_CHECKS : PHASE_CHECKS;
      for (int n = 0; n < count; n++) send_random_check();
      in_valid <= 1'b0;
      calm = 1'b0;
    end
    drain();

    $display("Covered %0d clock checks over %0d alarm table settings, spare indexes included.",
             checks_sent, settings_loaded);
    $display("Compared %0d results: %0d with a valve opened, %0d with a valve closed.",
             sb.results_seen, sb.opens_seen, sb.closes_seen);
    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
